// ===== rtl/omec_pkg.sv =====
package omec_pkg;

  // width of each count field in a result
  localparam int FIELD_W = 24;
  // default width of the internal saturating counters
  localparam int COUNT_WIDTH_DEF = 24;
  localparam int TOKEN_W = 8;

  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_V     = 8'h76;
  localparam logic [7:0] CHAR_F     = 8'h66;
  localparam logic [7:0] CHAR_T     = 8'h74;
  localparam logic [7:0] CHAR_N     = 8'h6e;

  // a fan of n corners makes n minus this many triangles
  localparam logic [TOKEN_W-1:0] FAN_BASE  = 8'd2;
  localparam logic [TOKEN_W-1:0] FAN_MIN   = 8'd3;
  localparam logic [TOKEN_W-1:0] TOKEN_MAX = 8'hff;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,  // skipping to the next newline
    MODE_LINE = 4'b0010,  // first character of a line
    MODE_VERT = 4'b0100,  // seen 'v'
    MODE_FACE = 4'b1000   // inside a face line
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] vertex_count;
    logic [FIELD_W-1:0] normal_count;
    logic [FIELD_W-1:0] texcoord_count;
    logic [FIELD_W-1:0] triangle_count;
    logic               has_normals;
    logic               has_texcoords;
  } out_t;

endpackage

// ===== rtl/omec_scan.sv =====
module omec_scan
  import omec_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  in_t  item,
  output out_t result
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  scan_mode_t             scan_mode, scan_mode_next;
  logic                   after_space, after_space_next;
  logic [TOKEN_W-1:0]     face_tokens, face_tokens_next;
  logic [COUNT_WIDTH-1:0] vertices_seen, vertices_seen_next;
  logic [COUNT_WIDTH-1:0] normals_seen, normals_seen_next;
  logic [COUNT_WIDTH-1:0] texcoords_seen, texcoords_seen_next;
  logic [COUNT_WIDTH-1:0] triangles_seen, triangles_seen_next;
  logic                   normal_flag, normal_flag_next;
  logic                   texcoord_flag, texcoord_flag_next;

  logic [COUNT_WIDTH:0]   tri_sum;
  logic [7:0]             c;

  assign c = item.text_byte;
  assign tri_sum = {1'b0, triangles_seen} + (COUNT_WIDTH+1)'(face_tokens - FAN_BASE);

  always_comb begin
    scan_mode_next      = scan_mode;
    after_space_next    = after_space;
    face_tokens_next    = face_tokens;
    vertices_seen_next  = vertices_seen;
    normals_seen_next   = normals_seen;
    texcoords_seen_next = texcoords_seen;
    triangles_seen_next = triangles_seen;
    normal_flag_next    = normal_flag;
    texcoord_flag_next  = texcoord_flag;
    case (scan_mode)
      MODE_IDLE: begin
        if (c == CHAR_NL) scan_mode_next = MODE_LINE;
      end
      MODE_LINE: begin
        if (c == CHAR_V) scan_mode_next = MODE_VERT;
        else if (c == CHAR_F) scan_mode_next = MODE_FACE;
        else scan_mode_next = MODE_IDLE;
      end
      MODE_VERT: begin
        if (c == CHAR_SPACE) begin
          if (vertices_seen != COUNT_MAX) begin
            vertices_seen_next = vertices_seen + COUNT_WIDTH'(1);
          end
        end else if (c == CHAR_T) begin
          if (texcoords_seen != COUNT_MAX) begin
            texcoords_seen_next = texcoords_seen + COUNT_WIDTH'(1);
          end
          texcoord_flag_next = 1'b1;
        end else if (c == CHAR_N) begin
          if (normals_seen != COUNT_MAX) begin
            normals_seen_next = normals_seen + COUNT_WIDTH'(1);
          end
          normal_flag_next = 1'b1;
        end
        scan_mode_next = MODE_IDLE;
      end
      MODE_FACE: begin
        if (c == CHAR_NL || c == CHAR_HASH) begin
          // fan split: tokens minus two triangles
          if (face_tokens >= FAN_MIN) begin
            triangles_seen_next = tri_sum[COUNT_WIDTH] ? COUNT_MAX
                                                       : tri_sum[COUNT_WIDTH-1:0];
          end
          face_tokens_next = '0;
          after_space_next = 1'b0;
          scan_mode_next   = MODE_LINE;
        end else if (c == CHAR_SPACE) begin
          after_space_next = 1'b1;
        end else if (after_space && (c inside {[CHAR_ZERO:CHAR_NINE]})) begin
          if (face_tokens != TOKEN_MAX) face_tokens_next = face_tokens + TOKEN_W'(1);
          after_space_next = 1'b0;
        end
      end
      default: begin
        scan_mode_next = MODE_IDLE;
      end
    endcase
  end

  // counts as seen after this byte, cut or widened to the field width
  logic [FIELD_W+COUNT_WIDTH-1:0] vert_ext, norm_ext, tex_ext, tri_ext;
  assign vert_ext = {{FIELD_W{1'b0}}, vertices_seen_next};
  assign norm_ext = {{FIELD_W{1'b0}}, normals_seen_next};
  assign tex_ext  = {{FIELD_W{1'b0}}, texcoords_seen_next};
  assign tri_ext  = {{FIELD_W{1'b0}}, triangles_seen_next};

  always_comb begin
    result.vertex_count   = vert_ext[FIELD_W-1:0];
    result.normal_count   = norm_ext[FIELD_W-1:0];
    result.texcoord_count = tex_ext[FIELD_W-1:0];
    result.triangle_count = tri_ext[FIELD_W-1:0];
    result.has_normals    = normal_flag_next;
    result.has_texcoords  = texcoord_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.end_of_file)) begin
      // last byte of a file starts the next one from scratch
      scan_mode      <= MODE_IDLE;
      after_space    <= 1'b0;
      face_tokens    <= '0;
      vertices_seen  <= '0;
      normals_seen   <= '0;
      texcoords_seen <= '0;
      triangles_seen <= '0;
      normal_flag    <= 1'b0;
      texcoord_flag  <= 1'b0;
    end else if (take) begin
      scan_mode      <= scan_mode_next;
      after_space    <= after_space_next;
      face_tokens    <= face_tokens_next;
      vertices_seen  <= vertices_seen_next;
      normals_seen   <= normals_seen_next;
      texcoords_seen <= texcoords_seen_next;
      triangles_seen <= triangles_seen_next;
      normal_flag    <= normal_flag_next;
      texcoord_flag  <= texcoord_flag_next;
    end
  end

endmodule

// ===== rtl/obj_mesh_element_counter_top.sv =====
// mesh text element counter
// byte channel: byte_valid / byte_stall / byte_data carry one character of
//   a mesh text file per transfer, with end_of_file set on the last one
// count channel: count_valid / count_stall / count_data carry one result per
//   file: vertex, normal, texcoord and triangle counts plus two flags
// throughput: one byte per clock while byte_stall is low; the scanner state is
//   updated in the cycle a byte transfers, so every unstalled cycle can take a byte
// latency: the result of a file is valid the cycle after its last byte
//   transfers and sits in the output register until taken
// stall: byte_stall rises only while a result waits and count_stall is high;
//   the output register then holds, and a new last byte could not be stored
// reset: rst (synchronous) empties the output register and clears all
//   counters; the first line of each file is never classified
// counters are COUNT_WIDTH bits wide and saturate; each field shows the low
//   24 bits of its counter
module obj_mesh_element_counter_top
  import omec_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic byte_valid,
  output logic byte_stall,
  input  in_t  byte_data,
  output logic count_valid,
  input  logic count_stall,
  output out_t count_data
);

  logic take;
  out_t result;

  // hold off input only while a result is stuck in the output register
  assign byte_stall = count_valid && count_stall;
  assign take       = byte_valid && !byte_stall;

  omec_scan #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (byte_data),
    .result(result)
  );

  // output register: loaded on the last byte of a file
  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= 1'b0;
    end else if (take && byte_data.end_of_file) begin
      count_valid <= 1'b1;
    end else if (!count_stall) begin
      count_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && byte_data.end_of_file) begin
      count_data <= result;
    end
  end

endmodule

// ===== rtl/omec_check.sv =====
module omec_check
  import omec_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic byte_valid,
  input logic byte_stall,
  input in_t  byte_data,
  input logic count_valid,
  input logic count_stall,
  input out_t count_data
);

  // a waiting result holds steady
  assert property (@(posedge clk) disable iff (rst)
    count_valid && count_stall |=> count_valid && $stable(count_data))
    else $error("stalled result changed");

  // the last byte of a file produces a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && byte_data.end_of_file |=> count_valid)
    else $error("missing result after last byte");

  // a result appears only after a last byte
  assert property (@(posedge clk) disable iff (rst)
    $rose(count_valid) |-> $past(byte_valid && !byte_stall && byte_data.end_of_file))
    else $error("result without last byte");

  // input is held off only behind a waiting result
  assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> count_valid)
    else $error("input stalled with empty output");

  // a clear flag comes with a zero count
  assert property (@(posedge clk) disable iff (rst)
    count_valid && (!count_data.has_normals || !count_data.has_texcoords) |->
      (count_data.has_normals || count_data.normal_count == '0) &&
      (count_data.has_texcoords || count_data.texcoord_count == '0))
    else $error("flag clear with nonzero count");

endmodule

bind obj_mesh_element_counter_top omec_check u_check (.*);
